// ===== design/pctlb_pkg.sv =====
`default_nettype none
package pctlb_pkg;

	localparam int MAX_CPUS = 4;
	localparam int MAX_SETS = 512;
	localparam int MAX_WAYS = 4;

	localparam int SET_W  = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
	localparam int SCNT_W = $clog2(MAX_SETS + 1);
	localparam int WAY_W  = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
	localparam int WCNT_W = $clog2(MAX_WAYS + 1);
	localparam int CPU_W  = (MAX_CPUS > 1) ? $clog2(MAX_CPUS) : 1;
	localparam int CCNT_W = $clog2(MAX_CPUS + 1);
	localparam int ROWS   = MAX_CPUS * MAX_SETS;
	localparam int ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;

	localparam int APB_AW = 4;
	localparam int APB_DW = 32;

	localparam logic [1:0] REG_SETS = 2'd0;
	localparam logic [1:0] REG_WAYS = 2'd1;
	localparam logic [1:0] REG_CPUS = 2'd2;

	typedef struct packed {
		logic        valid;
		logic [63:0] tag;
		logic [63:0] stamp;
	} entry_t;

	typedef entry_t [MAX_WAYS-1:0] row_t;

	typedef struct packed {
		logic [SCNT_W-1:0] sets;
		logic [WCNT_W-1:0] ways;
		logic [CCNT_W-1:0] cpus;
	} cfg_t;

endpackage
`default_nettype wire

// ===== design/pctlb_if.sv =====
`default_nettype none
interface pctlb_req_if;
	logic        valid;
	logic        ready;
	logic        mode;
	logic [1:0]  cpu;
	logic [63:0] page;

	modport source (output valid, mode, cpu, page, input ready);
	modport sink (input valid, mode, cpu, page, output ready);
endinterface

interface pctlb_rsp_if;
	logic       valid;
	logic       ready;
	logic       hit;
	logic       cpu_error;
	logic [2:0] cleared_count;

	modport source (output valid, hit, cpu_error, cleared_count, input ready);
	modport sink (input valid, hit, cpu_error, cleared_count, output ready);
endinterface
`default_nettype wire

// ===== design/pctlb_ram.sv =====
`default_nettype none
module pctlb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

// ===== design/pctlb_way_cmp.sv =====
`default_nettype none
module pctlb_way_cmp
	import pctlb_pkg::*;
(
	input  wire entry_t      ent,
	input  wire logic [63:0] page,
	input  wire logic [63:0] best_stamp,
	output logic             match,
	output logic             older
);

	assign match = ent.valid && (ent.tag == page);
	assign older = (ent.stamp < best_stamp);

endmodule
`default_nettype wire

// ===== design/pctlb_cfg.sv =====
`default_nettype none
module pctlb_cfg
	import pctlb_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [APB_AW-1:0] paddr,
	input  wire logic [APB_DW-1:0] pwdata,
	output logic      [APB_DW-1:0] prdata,
	output logic                   pready,
	output cfg_t                   cfg
);

	logic [9:0] sets_q;
	logic [2:0] ways_q;
	logic [2:0] cpus_q;
	logic       wen;

	assign pready = 1'b1;
	assign wen    = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sets_q <= 10'(MAX_SETS);
			ways_q <= 3'(MAX_WAYS);
			cpus_q <= 3'(MAX_CPUS);
		end else if (wen) begin
			unique case (paddr[3:2])
				REG_SETS: sets_q <= pwdata[9:0];
				REG_WAYS: ways_q <= pwdata[2:0];
				REG_CPUS: cpus_q <= pwdata[2:0];
				default:  ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			REG_SETS: prdata = APB_DW'(sets_q);
			REG_WAYS: prdata = APB_DW'(ways_q);
			REG_CPUS: prdata = APB_DW'(cpus_q);
			default:  prdata = '0;
		endcase
	end

	always_comb begin
		cfg.sets = (32'(sets_q) > MAX_SETS) ? SCNT_W'(MAX_SETS) : SCNT_W'(sets_q);
		if (ways_q == 3'd0) begin
			cfg.ways = WCNT_W'(1);
		end else begin
			cfg.ways = (32'(ways_q) > MAX_WAYS) ? WCNT_W'(MAX_WAYS) : WCNT_W'(ways_q);
		end
		cfg.cpus = (32'(cpus_q) > MAX_CPUS) ? CCNT_W'(MAX_CPUS) : CCNT_W'(cpus_q);
	end

endmodule
`default_nettype wire

// ===== design/percpu_set_assoc_tlb_lru_core.sv =====
// Per-CPU set-associative TLB with timestamp LRU replacement.
// Requests arrive on req_ch (mode, cpu, page) and each produces exactly one
// response on rsp_ch (hit, cpu_error, cleared_count); both use valid/ready.
// Registers sets_in_use, ways_in_use and cpus_in_use sit on the APB port at
// byte addresses 0, 4 and 8 and should be written only while the block is idle.
// All slices live in one RAM, one row per CPU and set, holding every way.
// An access, from acceptance to response, passes through one RAM read, one row
// load, a scan of each way in use through the shared tag and stamp comparator,
// one write-back and the load of the response register.
// An invalidate repeats the read, load, scan and write-back for every CPU slice
// in use before its response. Disabled lookups and CPU errors skip the RAM and
// go straight to the response register. One request is in flight at a time.
// After reset the RAM is cleared one row per cycle, all 2048 rows, during which
// req_ch.ready stays low; configuration writes are taken throughout.
// The response register lets the next request be accepted while a response
// waits; a stalled receiver holds the following result until it is taken.
`default_nettype none
module percpu_set_assoc_tlb_lru_core
	import pctlb_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	pctlb_req_if.sink              req_ch,
	pctlb_rsp_if.source            rsp_ch,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [APB_AW-1:0] paddr,
	input  wire logic [APB_DW-1:0] pwdata,
	output logic      [APB_DW-1:0] prdata,
	output logic                   pready
);

	typedef enum logic [2:0] {CLEAR, IDLE, READ, LOAD, SCAN, WRITE, DONE} state_t;

	state_t             st_q;
	cfg_t               cfg;
	logic [ROW_W-1:0]   clr_q;
	logic [63:0]        clock_q;
	logic               mode_q;
	logic [CPU_W-1:0]   cpu_q;
	logic [63:0]        page_q;
	logic [SET_W-1:0]   set_q;
	logic [WCNT_W-1:0]  ways_q;
	logic [CCNT_W-1:0]  cpus_q;
	row_t               row_q;
	logic [WAY_W-1:0]   w_q;
	logic               hit_q;
	logic [WAY_W-1:0]   hit_way_q;
	logic               inv_f_q;
	logic [WAY_W-1:0]   inv_way_q;
	logic [WAY_W-1:0]   lru_way_q;
	logic [63:0]        best_q;
	logic               err_q;
	logic [CCNT_W-1:0]  cnt_q;
	logic               out_valid_q;
	logic               out_hit_q;
	logic               out_err_q;
	logic [2:0]         out_cnt_q;

	logic [SET_W-1:0]   set_mask;
	logic [SET_W-1:0]   set_idx;
	logic [ROW_W-1:0]   row_addr;
	row_t               rdata;
	row_t               row_w;
	logic [WAY_W-1:0]   vict;
	entry_t             ent;
	logic               cmp_match;
	logic               cmp_older;
	logic               ram_we;
	logic [ROW_W-1:0]   ram_waddr;
	row_t               ram_wdata;

	pctlb_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	assign set_mask = SET_W'(cfg.sets - SCNT_W'(1));
	assign set_idx  = req_ch.page[SET_W-1:0] & set_mask;
	assign row_addr = ROW_W'(ROW_W'(cpu_q) * ROW_W'(MAX_SETS)) + ROW_W'(set_q);

	assign ent = row_q[w_q];

	pctlb_way_cmp u_cmp (
		.ent        (ent),
		.page       (page_q),
		.best_stamp (best_q),
		.match      (cmp_match),
		.older      (cmp_older)
	);

	assign vict = hit_q ? hit_way_q : (inv_f_q ? inv_way_q : lru_way_q);

	always_comb begin
		row_w = row_q;
		if (mode_q) begin
			if (hit_q) begin
				row_w[vict].valid = 1'b0;
			end
		end else begin
			row_w[vict].stamp = clock_q;
			if (!hit_q) begin
				row_w[vict].valid = 1'b1;
				row_w[vict].tag   = page_q;
			end
		end
	end

	assign ram_we    = (st_q == CLEAR) || (st_q == WRITE);
	assign ram_waddr = (st_q == CLEAR) ? clr_q : row_addr;
	assign ram_wdata = (st_q == CLEAR) ? row_t'('0) : row_w;

	pctlb_ram #(
		.WIDTH ($bits(row_t)),
		.DEPTH (ROWS)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (row_addr),
		.rdata (rdata)
	);

	assign req_ch.ready         = (st_q == IDLE);
	assign rsp_ch.valid         = out_valid_q;
	assign rsp_ch.hit           = out_hit_q;
	assign rsp_ch.cpu_error     = out_err_q;
	assign rsp_ch.cleared_count = out_cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= CLEAR;
			clr_q       <= '0;
			clock_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if ((st_q == DONE) && (!out_valid_q || rsp_ch.ready)) begin
				out_valid_q <= 1'b1;
				out_hit_q   <= hit_q && !mode_q;
				out_err_q   <= err_q;
				out_cnt_q   <= 3'(cnt_q);
			end else if (rsp_ch.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (st_q)
				CLEAR: begin
					clr_q <= clr_q + ROW_W'(1);
					if (clr_q == ROW_W'(ROWS - 1)) begin
						st_q <= IDLE;
					end
				end
				IDLE: begin
					if (req_ch.valid) begin
						mode_q <= req_ch.mode;
						cpu_q  <= req_ch.mode ? CPU_W'(0) : CPU_W'(req_ch.cpu);
						page_q <= req_ch.page;
						set_q  <= set_idx;
						ways_q <= cfg.ways;
						cpus_q <= cfg.cpus;
						hit_q  <= 1'b0;
						err_q  <= 1'b0;
						cnt_q  <= '0;
						if (cfg.sets == '0) begin
							st_q <= DONE;
						end else if (!req_ch.mode && (CCNT_W'(req_ch.cpu) >= cfg.cpus)) begin
							err_q <= 1'b1;
							st_q  <= DONE;
						end else if (req_ch.mode && (cfg.cpus == '0)) begin
							st_q <= DONE;
						end else begin
							st_q <= READ;
						end
					end
				end
				READ: begin
					st_q <= LOAD;
				end
				LOAD: begin
					row_q   <= rdata;
					w_q     <= '0;
					hit_q   <= 1'b0;
					inv_f_q <= 1'b0;
					st_q    <= SCAN;
				end
				SCAN: begin
					if (!hit_q && cmp_match) begin
						hit_q     <= 1'b1;
						hit_way_q <= w_q;
					end
					if (!inv_f_q && !ent.valid) begin
						inv_f_q   <= 1'b1;
						inv_way_q <= w_q;
					end
					if ((w_q == '0) || cmp_older) begin
						lru_way_q <= w_q;
						best_q    <= ent.stamp;
					end
					if (w_q == WAY_W'(ways_q - WCNT_W'(1))) begin
						st_q <= WRITE;
					end else begin
						w_q <= w_q + WAY_W'(1);
					end
				end
				WRITE: begin
					if (!mode_q) begin
						clock_q <= clock_q + 64'd1;
						st_q    <= DONE;
					end else begin
						if (hit_q) begin
							cnt_q <= cnt_q + CCNT_W'(1);
						end
						if (cpu_q == CPU_W'(cpus_q - CCNT_W'(1))) begin
							st_q <= DONE;
						end else begin
							cpu_q <= cpu_q + CPU_W'(1);
							st_q  <= READ;
						end
					end
				end
				DONE: begin
					if (!out_valid_q || rsp_ch.ready) begin
						st_q <= IDLE;
					end
				end
				default: begin
					st_q <= IDLE;
				end
			endcase
		end
	end

	// The access clock moves only when an access writes back its row.
	assert property (@(posedge clk) disable iff (!arst_n)
		!((st_q == WRITE) && !mode_q) |=> $stable(clock_q))
		else $error("access clock changed outside an access write-back");

	// A response never reports a hit together with a CPU error.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(out_hit_q && out_err_q))
		else $error("response carries both hit and cpu_error");

	// The way scan stays within the associativity latched for the request.
	assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == SCAN) |-> (w_q < ways_q))
		else $error("way index beyond ways in use");

	// An invalidate clears at most one way per CPU slice in use.
	assert property (@(posedge clk) disable iff (!arst_n)
		((st_q == DONE) && mode_q) |-> (cnt_q <= cpus_q))
		else $error("cleared count exceeds CPU slices in use");

endmodule
`default_nettype wire

// ===== test/tb_percpu_set_assoc_tlb_lru_core.sv =====
`timescale 1ns / 100ps
module tb_percpu_set_assoc_tlb_lru_core
	import pctlb_pkg::*;
();

	localparam logic MODE_ACCESS = 1'b0;
	localparam logic MODE_INVAL  = 1'b1;
	localparam logic [1:0] REG_SPARE = 2'd3;
	localparam int CYCLE_LIMIT = 300000;
	localparam int PHASES = 8;
	localparam int PHASE_ITEMS = 75;
	localparam int POOL_SIZE = 12;

	typedef enum logic {ROW_WRITE, ROW_REQUEST} row_kind_t;

	typedef struct packed {
		logic        mode;
		logic [1:0]  cpu;
		logic [63:0] page;
	} tlb_request_t;

	typedef struct packed {
		logic       hit;
		logic       cpu_error;
		logic [2:0] cleared;
	} tlb_result_t;

	typedef struct packed {
		row_kind_t    kind;
		logic [1:0]   reg_idx;
		logic [31:0]  reg_val;
		tlb_request_t rq;
		logic         typed;
		tlb_result_t  want;
	} stim_row_t;

	logic clk;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [APB_AW-1:0] paddr;
	logic [APB_DW-1:0] pwdata;
	logic [APB_DW-1:0] prdata;
	logic pready;

	pctlb_req_if req_ch();
	pctlb_rsp_if rsp_ch();

	percpu_set_assoc_tlb_lru_core dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.req_ch  (req_ch),
		.rsp_ch  (rsp_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	bit          way_valid [MAX_CPUS][MAX_SETS][MAX_WAYS];
	logic [63:0] way_tag   [MAX_CPUS][MAX_SETS][MAX_WAYS];
	logic [63:0] way_stamp [MAX_CPUS][MAX_SETS][MAX_WAYS];
	logic [63:0] use_clock;
	logic [9:0]  cfg_sets;
	logic [2:0]  cfg_ways;
	logic [2:0]  cfg_cpus;

	tlb_result_t pending_results[$];
	stim_row_t   directed_rows[$];
	logic [63:0] page_pool[POOL_SIZE];
	int          failures;
	int          cycles;
	bit          calm;

	function automatic tlb_result_t lookup_tlb(tlb_request_t rq);
		int sets, ways, cpus, set_idx, victim;
		bit found;
		tlb_result_t res;
		res = '0;
		sets = (cfg_sets > MAX_SETS) ? MAX_SETS : int'(cfg_sets);
		ways = (cfg_ways == 0) ? 1 : ((cfg_ways > MAX_WAYS) ? MAX_WAYS : int'(cfg_ways));
		cpus = (cfg_cpus > MAX_CPUS) ? MAX_CPUS : int'(cfg_cpus);
		if (sets == 0)
			return res;
		set_idx = int'(rq.page[SET_W-1:0]) & (sets - 1);
		if (rq.mode == MODE_INVAL) begin
			for (int c = 0; c < cpus; c++) begin
				found = 1'b0;
				for (int w = 0; w < ways; w++) begin
					if (!found && way_valid[c][set_idx][w] && way_tag[c][set_idx][w] == rq.page) begin
						way_valid[c][set_idx][w] = 1'b0;
						res.cleared++;
						found = 1'b1;
					end
				end
			end
			return res;
		end
		if (int'(rq.cpu) >= cpus) begin
			res.cpu_error = 1'b1;
			return res;
		end
		victim = -1;
		for (int w = 0; w < ways; w++)
			if (victim < 0 && way_valid[rq.cpu][set_idx][w] &&
					way_tag[rq.cpu][set_idx][w] == rq.page)
				victim = w;
		res.hit = (victim >= 0);
		if (!res.hit) begin
			for (int w = 0; w < ways; w++)
				if (victim < 0 && !way_valid[rq.cpu][set_idx][w])
					victim = w;
			if (victim < 0) begin
				victim = 0;
				for (int w = 1; w < ways; w++)
					if (way_stamp[rq.cpu][set_idx][w] < way_stamp[rq.cpu][set_idx][victim])
						victim = w;
			end
			way_valid[rq.cpu][set_idx][victim] = 1'b1;
			way_tag[rq.cpu][set_idx][victim] = rq.page;
		end
		way_stamp[rq.cpu][set_idx][victim] = use_clock;
		use_clock++;
		return res;
	endfunction

	task automatic apb_write(input logic [1:0] idx, input logic [31:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= APB_AW'({idx, 2'b00});
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		case (idx)
			REG_SETS: cfg_sets = val[9:0];
			REG_WAYS: cfg_ways = val[2:0];
			REG_CPUS: cfg_cpus = val[2:0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic issue_request(input tlb_request_t rq, input logic typed, input tlb_result_t want);
		tlb_result_t predicted;
		while (!calm && $urandom_range(0, 99) < 8) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.mode <= rq.mode;
		req_ch.cpu <= rq.cpu;
		req_ch.page <= rq.page;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
		predicted = lookup_tlb(rq);
		pending_results.push_back(typed ? want : predicted);
	endtask

	task automatic wait_quiet();
		req_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	function automatic void add_request(logic mode, logic [1:0] cpu, logic [63:0] page,
			logic typed, logic hit, logic cpu_error, logic [2:0] cleared);
		stim_row_t row;
		row = '0;
		row.kind = ROW_REQUEST;
		row.rq = '{mode: mode, cpu: cpu, page: page};
		row.typed = typed;
		row.want = '{hit: hit, cpu_error: cpu_error, cleared: cleared};
		directed_rows.push_back(row);
	endfunction

	function automatic void add_write(logic [1:0] idx, logic [31:0] val);
		stim_row_t row;
		row = '0;
		row.kind = ROW_WRITE;
		row.reg_idx = idx;
		row.reg_val = val;
		directed_rows.push_back(row);
	endfunction

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("tb_percpu_set_assoc_tlb_lru_core NOT OK");
		$finish;
	end

	initial begin
		tlb_result_t got, want;
		rsp_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (rsp_ch.valid && rsp_ch.ready) begin
				got = '{hit: rsp_ch.hit, cpu_error: rsp_ch.cpu_error, cleared: rsp_ch.cleared_count};
				if (pending_results.size() == 0) begin
					failures++;
					if (failures <= 10)
						$display("unexpected response hit=%b cpu_error=%b cleared=%0d",
							got.hit, got.cpu_error, got.cleared);
				end else begin
					want = pending_results.pop_front();
					if (got.hit !== want.hit || got.cpu_error !== want.cpu_error ||
							got.cleared !== want.cleared) begin
						failures++;
						if (failures <= 10)
							$display("mismatch: expected hit=%b cpu_error=%b cleared=%0d,",
								want.hit, want.cpu_error, want.cleared,
								" got hit=%b cpu_error=%b cleared=%0d",
								got.hit, got.cpu_error, got.cleared);
					end
				end
			end
			rsp_ch.ready <= calm || ($urandom_range(0, 99) >= 8);
		end
	end

	initial begin
		int ph_sets[PHASES];
		int ph_ways[PHASES];
		int ph_cpus[PHASES];
		logic [8:0] slots[3];
		tlb_request_t rq;
		int sv, wv, cv;

		ph_sets = '{512, 1, 2, 512, 1023, 3, -1, -1};
		ph_ways = '{4, 4, 1, 7, 0, 2, -1, -1};
		ph_cpus = '{4, 4, 3, 7, 1, 4, -1, -1};
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		req_ch.valid = 1'b0;
		req_ch.mode = MODE_ACCESS;
		req_ch.cpu = '0;
		req_ch.page = '0;
		use_clock = '0;
		cfg_sets = 10'(MAX_SETS);
		cfg_ways = 3'(MAX_WAYS);
		cfg_cpus = 3'(MAX_CPUS);
		failures = 0;
		cycles = 0;
		calm = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		add_request(MODE_ACCESS, 2'd0, 64'h0, 1, 0, 0, 0);
		add_request(MODE_ACCESS, 2'd0, 64'h0, 1, 1, 0, 0);
		add_request(MODE_ACCESS, 2'd3, '1, 1, 0, 0, 0);
		add_request(MODE_INVAL, 2'd3, 64'h0, 1, 0, 0, 1);
		add_request(MODE_INVAL, 2'd0, 64'h0, 1, 0, 0, 0);
		add_request(MODE_ACCESS, 2'd1, 64'h200, 0, 0, 0, 0);
		add_request(MODE_ACCESS, 2'd1, 64'h400, 0, 0, 0, 0);
		add_request(MODE_ACCESS, 2'd1, 64'h600, 0, 0, 0, 0);
		add_request(MODE_ACCESS, 2'd1, 64'h800, 0, 0, 0, 0);
		add_request(MODE_ACCESS, 2'd1, 64'h200, 0, 0, 0, 0);
		add_request(MODE_ACCESS, 2'd1, 64'hA00, 0, 0, 0, 0);
		add_request(MODE_ACCESS, 2'd1, 64'h400, 0, 0, 0, 0);
		add_request(MODE_ACCESS, 2'd0, 64'h200, 0, 0, 0, 0);
		add_request(MODE_ACCESS, 2'd2, 64'h200, 0, 0, 0, 0);
		add_request(MODE_ACCESS, 2'd3, 64'h200, 0, 0, 0, 0);
		add_request(MODE_INVAL, 2'd0, 64'h200, 1, 0, 0, 4);
		add_write(REG_CPUS, 32'd2);
		add_request(MODE_ACCESS, 2'd2, 64'h1, 1, 0, 1, 0);
		add_request(MODE_ACCESS, 2'd1, 64'h1, 0, 0, 0, 0);
		add_write(REG_CPUS, 32'd0);
		add_request(MODE_ACCESS, 2'd0, 64'h1, 1, 0, 1, 0);
		add_request(MODE_INVAL, 2'd0, 64'h1, 1, 0, 0, 0);
		add_write(REG_SETS, 32'd0);
		add_write(REG_CPUS, 32'd4);
		add_request(MODE_ACCESS, 2'd3, 64'h400, 1, 0, 0, 0);
		add_request(MODE_INVAL, 2'd0, 64'h400, 1, 0, 0, 0);
		add_write(REG_SETS, 32'd1023);
		add_write(REG_WAYS, 32'd0);
		add_write(REG_CPUS, 32'd7);
		add_write(REG_SPARE, 32'hFFFF_FFFF);
		add_request(MODE_ACCESS, 2'd3, 64'h400, 0, 0, 0, 0);
		add_request(MODE_INVAL, 2'd0, 64'h400, 0, 0, 0, 0);
		add_request(MODE_ACCESS, 2'd0, 64'h8000_0000_0000_0000, 0, 0, 0, 0);

		foreach (directed_rows[i]) begin
			if (directed_rows[i].kind == ROW_WRITE) begin
				wait_quiet();
				apb_write(directed_rows[i].reg_idx, directed_rows[i].reg_val);
			end else begin
				issue_request(directed_rows[i].rq, directed_rows[i].typed, directed_rows[i].want);
			end
		end

		// Most requests reuse a small pool of pages that share a few sets, so that
		// hits, refills, LRU evictions and multi-slice invalidates are frequent.
		for (int p = 0; p < PHASES; p++) begin
			wait_quiet();
			calm = (p == 2);
			sv = (ph_sets[p] < 0) ? (1 << $urandom_range(0, 9)) : ph_sets[p];
			wv = (ph_ways[p] < 0) ? $urandom_range(0, 7) : ph_ways[p];
			cv = (ph_cpus[p] < 0) ? $urandom_range(1, 7) : ph_cpus[p];
			apb_write(REG_SETS, {22'($urandom_range(0, 4194303)), 10'(sv)});
			apb_write(REG_WAYS, {29'($urandom), 3'(wv)});
			apb_write(REG_CPUS, {29'($urandom), 3'(cv)});
			foreach (slots[k])
				slots[k] = 9'($urandom);
			foreach (page_pool[k]) begin
				page_pool[k] = {$urandom, $urandom};
				page_pool[k][8:0] = slots[k % 3];
			end
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				rq.mode = ($urandom_range(0, 99) < 15) ? MODE_INVAL : MODE_ACCESS;
				rq.cpu = 2'($urandom_range(0, 3));
				if ($urandom_range(0, 99) < 75)
					rq.page = page_pool[$urandom_range(0, POOL_SIZE - 1)];
				else
					rq.page = {$urandom, $urandom};
				if ($urandom_range(0, 49) == 0)
					wait_quiet();
				issue_request(rq, 1'b0, '0);
			end
		end

		wait_quiet();
		repeat (60) @(posedge clk);
		if (failures == 0 && pending_results.size() == 0)
			$display("tb_percpu_set_assoc_tlb_lru_core OK");
		else
			$display("tb_percpu_set_assoc_tlb_lru_core NOT OK");
		$finish;
	end

endmodule
